// File: sv/awo_pkg.sv
// shared types, constants and sine table for the additive oscillator bank
package awo_pkg;

  // bank geometry
  localparam int PARTIALS   = 256;
  localparam int TABLE_SIZE = 512;
  localparam int IDX_W      = (PARTIALS > 1) ? $clog2(PARTIALS) : 1;

  // field widths
  localparam int OP_W   = 2;
  localparam int PIDX_W = 8;
  localparam int AMP_W  = 16;
  localparam int HZ_W   = 14;
  localparam int SMP_W  = 16;

  // phase in 9.16 format, increment fits in 24 bits for any 14-bit frequency
  localparam int PH_W      = 25;
  localparam int PH_FRAC   = 16;
  localparam int INC_W     = 24;
  localparam int TAB_IDX_W = 9;
  localparam logic [PH_W:0]   PH_TURN  = (PH_W+1)'(TABLE_SIZE * (2**PH_FRAC));
  localparam logic [PH_W-1:0] PH_CLAMP = PH_W'((TABLE_SIZE - 1) * (2**PH_FRAC));

  // increment: round(hz * 2^25 / 44100)
  //   = hz * 760 + floor((hz * 38432 + 22050) / 44100), since 2^25 = 760 * 44100 + 38432
  // the remaining quotient comes from a reciprocal multiply, exact below 2^30
  localparam int INC_X_W    = 30;
  localparam int INC_Q_W    = 14;
  localparam int INC_RCP_W  = 31;
  localparam int INC_RCP_SH = 46;
  localparam int INC_PRD_W  = INC_RCP_SH + INC_Q_W;
  localparam logic [9:0]           INC_WHOLE = 10'd760;
  localparam logic [15:0]          INC_FRAC  = 16'd38432;
  localparam logic [INC_X_W-1:0]   INC_ROUND = INC_X_W'(22050);
  localparam logic [INC_RCP_W-1:0] INC_RECIP = INC_RCP_W'(1595663134);

  // products and accumulation
  localparam int PROD_W = 32;
  localparam int ACC_W  = (33 + $clog2(PARTIALS) > 36) ? 33 + $clog2(PARTIALS) : 36;
  localparam logic signed [ACC_W-1:0] ACC_LIM = ACC_W'(64'sd21474836480);

  // sample conversion: (mag * 17 + 6553600) / (2^19 * 25)
  localparam int MAG_W    = 35;
  localparam int X_W      = 39;
  localparam int T_SH     = 19;
  localparam int T_W      = 20;
  localparam int RECIP_W  = 21;
  localparam int RECIP_SH = 25;
  localparam int Q_W      = 15;
  localparam logic [X_W-1:0]     SMP_BIAS = X_W'(6553600);
  localparam logic [RECIP_W-1:0] RECIP25  = RECIP_W'(1342178);

  // operation codes
  localparam logic [OP_W-1:0] OP_TICK     = 2'd0;
  localparam logic [OP_W-1:0] OP_WR_LEFT  = 2'd1;
  localparam logic [OP_W-1:0] OP_WR_RIGHT = 2'd2;

  // configuration register index (address bits above the byte offset)
  localparam int          ADDR_W          = 3;
  localparam logic [0:0]  REG_PLAY_ENABLE = 1'b0;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [PIDX_W-1:0] partial_index;
    logic [AMP_W-1:0]  amplitude;
    logic [HZ_W-1:0]   frequency_hz;
  } in_req_t;

  typedef struct packed {
    logic signed [SMP_W-1:0] left_sample;
    logic signed [SMP_W-1:0] right_sample;
  } out_rsp_t;

  // one partial as held in a channel memory
  typedef struct packed {
    logic [AMP_W-1:0] amp;
    logic [INC_W-1:0] inc;
    logic [PH_W-1:0]  phase;
  } ent_t;

  // sequencer commands to one channel lane
  typedef struct packed {
    logic             rd;
    logic             tick;
    logic             last;
    logic             cfg_wr;
    logic             clr_wr;
    logic             acc_clr;
    logic [IDX_W-1:0] addr;
  } lane_ctl_t;

  // quarter-wave sine in millionths
  localparam int QUARTER_N = 129;
  localparam int unsigned QUARTER_MICRO [QUARTER_N] = '{
    0, 12268, 24536, 36804, 49042, 61310, 73547, 85785, 97992, 110200,
    122410, 134550, 146700, 158840, 170930, 183010, 195070, 207090, 219090, 231050,
    242950, 254850, 266690, 278500, 290250, 301970, 313660, 325290, 336850, 348390,
    359860, 371280, 382660, 393950, 405210, 416410, 427520, 438600, 449580, 460510,
    471370, 482150, 492860, 503510, 514070, 524570, 534970, 545290, 555540, 565700,
    575780, 585750, 595670, 605470, 615200, 624820, 634370, 643800, 653140, 662380,
    671510, 680570, 689510, 698330, 707060, 715700, 724210, 732600, 740910, 749080,
    757170, 765140, 772980, 780700, 788300, 795810, 803160, 810420, 817540, 824550,
    831420, 838200, 844820, 851320, 857700, 863920, 870060, 876040, 881870, 887600,
    893190, 898620, 903960, 909120, 914150, 919070, 923830, 928470, 932950, 937290,
    941500, 945560, 949490, 953250, 956910, 960390, 963750, 966920, 970000, 972900,
    975650, 978270, 980740, 983060, 985230, 987240, 989140, 990840, 992430, 993870,
    995150, 996280, 997250, 998080, 998750, 999270, 999660, 999880, 999970
  };

  localparam logic [63:0] MICRO_ONE = 64'd1000000;
  localparam logic [63:0] MICRO_HALF = 64'd500000;

  typedef logic [15:0] quarter_tab_t [QUARTER_N];

  // quarter wave rounded to q1.15, built at elaboration
  function automatic quarter_tab_t build_quarter();
    quarter_tab_t tab;
    for (int k = 0; k < QUARTER_N; k++) begin
      tab[k] = 16'((64'(QUARTER_MICRO[k]) * 64'd32768 + MICRO_HALF) / MICRO_ONE);
    end
    return tab;
  endfunction

  localparam quarter_tab_t QUARTER_Q15 = build_quarter();

  // full-wave table entry by mirroring the quarter wave
  function automatic logic signed [SMP_W-1:0] sine_at(input logic [TAB_IDX_W-1:0] j);
    logic [TAB_IDX_W-1:0]    k;
    logic                    neg;
    logic signed [SMP_W-1:0] mag;
    if (j <= 9'd128) begin
      k   = j;
      neg = 1'b0;
    end else if (j <= 9'd256) begin
      k   = 9'd256 - j;
      neg = 1'b0;
    end else if (j <= 9'd384) begin
      k   = j - 9'd256;
      neg = 1'b1;
    end else begin
      k   = 9'd0 - j;
      neg = 1'b1;
    end
    mag = $signed(QUARTER_Q15[k[7:0]]);
    return neg ? -mag : mag;
  endfunction

endpackage

// File: sv/awo_div.sv
// three-stage reciprocal calculation of the phase increment of a written partial
module awo_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [awo_pkg::HZ_W-1:0]   hz_i,
  output logic                       done_o,
  output logic [awo_pkg::INC_W-1:0]  inc_o
);
  import awo_pkg::*;

  logic                 stg1_q, stg2_q, done_q;
  logic [INC_W-1:0]     base1_q, base2_q, inc_q;
  logic [INC_X_W-1:0]   x1_q;
  logic [INC_Q_W-1:0]   quo2_q;
  logic [INC_PRD_W-1:0] prd;

  // stage valid flags, done is a single-cycle pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg1_q <= 1'b0;
      stg2_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      stg1_q <= start_i;
      stg2_q <= stg1_q;
      done_q <= stg2_q;
    end
  end

  // quotient of the remainder part by 44100
  assign prd = INC_PRD_W'(x1_q) * INC_PRD_W'(INC_RECIP);

  // whole part and remainder term, then reciprocal multiply, then final sum
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      base1_q <= INC_W'(hz_i) * INC_W'(INC_WHOLE);
      x1_q    <= INC_X_W'(hz_i) * INC_X_W'(INC_FRAC) + INC_ROUND;
    end
    if (stg1_q) begin
      base2_q <= base1_q;
      quo2_q  <= prd[INC_RCP_SH +: INC_Q_W];
    end
    if (stg2_q) begin
      inc_q <= base2_q + INC_W'(quo2_q);
    end
  end

  assign done_o = done_q;
  assign inc_o  = inc_q;

endmodule

// File: sv/awo_lane.sv
// one channel: partial memory, phase read-modify-write, mixing and sample scaling
module awo_lane (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  awo_pkg::lane_ctl_t                ctl_i,
  input  logic [awo_pkg::AMP_W-1:0]         amp_i,
  input  logic [awo_pkg::INC_W-1:0]         inc_i,
  output logic                              done_o,
  output logic signed [awo_pkg::SMP_W-1:0]  sample_o
);
  import awo_pkg::*;

  ent_t mem_q [PARTIALS];
  ent_t rdata_q;

  // pipeline flags
  logic tick1_q, tick2_q, tick3_q, tick4_q;
  logic last1_q, last2_q, last3_q, last4_q;
  logic sum_done_q, fin1_q, fin2_q;

  logic [IDX_W-1:0]           addr1_q;
  logic [TAB_IDX_W-1:0]       tidx2_q;
  logic [AMP_W-1:0]           amp2_q, amp3_q;
  logic signed [SMP_W-1:0]    sine3_q;
  logic signed [PROD_W-1:0]   prod4_q;
  logic signed [ACC_W-1:0]    acc_q;
  logic [T_W-1:0]             t_q;
  logic                       neg_q;
  logic [Q_W-1:0]             q_q;

  logic [PH_W:0]              ph_sum;
  logic [PH_W-1:0]            ph_new;
  logic                       ph_we;
  logic                       we;
  logic [IDX_W-1:0]           waddr;
  ent_t                       wdata;
  logic signed [AMP_W:0]      amp_s;
  logic signed [PROD_W-1:0]   prod_d;
  logic signed [ACC_W-1:0]    acc_c;
  logic                       neg_d;
  logic [MAG_W-1:0]           mag;
  logic [X_W-1:0]             x_d;
  logic [T_W+RECIP_W-1:0]     qprod;
  logic [SMP_W-1:0]           q_ext;

  // phase advance with wrap, clamped to zero just below a full turn
  always_comb begin
    ph_sum = {1'b0, rdata_q.phase} + (PH_W+1)'(rdata_q.inc);
    if (ph_sum >= PH_TURN) begin
      ph_new = PH_W'(ph_sum - PH_TURN);
    end else if (ph_sum[PH_W-1:0] >= PH_CLAMP) begin
      ph_new = '0;
    end else begin
      ph_new = ph_sum[PH_W-1:0];
    end
  end

  assign ph_we = tick1_q && (rdata_q.amp != '0);

  // write port select: clearing, partial update or phase write-back
  always_comb begin
    we    = 1'b0;
    waddr = ctl_i.addr;
    wdata = '0;
    if (ctl_i.clr_wr) begin
      we = 1'b1;
    end else if (ctl_i.cfg_wr) begin
      we          = 1'b1;
      wdata.amp   = amp_i;
      wdata.inc   = inc_i;
      wdata.phase = rdata_q.phase;
    end else if (ph_we) begin
      we          = 1'b1;
      waddr       = addr1_q;
      wdata       = rdata_q;
      wdata.phase = ph_new;
    end
  end

  // partial memory
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (ctl_i.rd) begin
      rdata_q <= mem_q[ctl_i.addr];
    end
  end

  // pipeline flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick1_q    <= 1'b0;
      tick2_q    <= 1'b0;
      tick3_q    <= 1'b0;
      tick4_q    <= 1'b0;
      last1_q    <= 1'b0;
      last2_q    <= 1'b0;
      last3_q    <= 1'b0;
      last4_q    <= 1'b0;
      sum_done_q <= 1'b0;
      fin1_q     <= 1'b0;
      fin2_q     <= 1'b0;
    end else begin
      tick1_q    <= ctl_i.rd && ctl_i.tick;
      last1_q    <= ctl_i.rd && ctl_i.tick && ctl_i.last;
      tick2_q    <= tick1_q;
      last2_q    <= last1_q;
      tick3_q    <= tick2_q;
      last3_q    <= last2_q;
      tick4_q    <= tick3_q;
      last4_q    <= last3_q;
      sum_done_q <= last4_q;
      fin1_q     <= sum_done_q;
      fin2_q     <= fin1_q;
    end
  end

  // table index, lookup and product stages
  assign amp_s  = $signed({1'b0, amp3_q});
  assign prod_d = sine3_q * amp_s;

  always_ff @(posedge clk_i) begin
    addr1_q <= ctl_i.addr;
    tidx2_q <= TAB_IDX_W'(ph_new[PH_W-1:PH_FRAC] + 1'b1);
    amp2_q  <= rdata_q.amp;
    sine3_q <= sine_at(tidx2_q);
    amp3_q  <= amp2_q;
    prod4_q <= prod_d;
  end

  // channel accumulator
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (ctl_i.acc_clr) begin
      acc_q <= '0;
    end else if (tick4_q) begin
      acc_q <= acc_q + ACC_W'(prod4_q);
    end
  end

  // clamp, magnitude and coarse scale
  always_comb begin
    if (acc_q > ACC_LIM) begin
      acc_c = ACC_LIM;
    end else if (acc_q < -ACC_LIM) begin
      acc_c = -ACC_LIM;
    end else begin
      acc_c = acc_q;
    end
    neg_d = acc_c[ACC_W-1];
    mag   = neg_d ? MAG_W'(-acc_c) : MAG_W'(acc_c);
    x_d   = {mag, 4'b0} + X_W'(mag) + SMP_BIAS;
  end

  // divide by 25 through the reciprocal
  assign qprod = t_q * RECIP25;

  always_ff @(posedge clk_i) begin
    if (sum_done_q) begin
      t_q   <= x_d[T_SH +: T_W];
      neg_q <= neg_d;
    end
    if (fin1_q) begin
      q_q <= qprod[RECIP_SH +: Q_W];
    end
  end

  assign q_ext    = {1'b0, q_q};
  assign sample_o = neg_q ? $signed(-q_ext) : $signed(q_ext);
  assign done_o   = fin2_q;

endmodule

// File: sv/additive_wavetable_oscillator_bank.sv
// top level: configuration port, item sequencer, two channel lanes and output register
//
// Stereo additive oscillator bank. Requests arrive on the in channel (valid/stall):
// a tick request makes one stereo frame, a write request sets the amplitude and
// frequency of one left or right partial. Each tick gives exactly one result on
// the out channel; writes and the unused operation code give none.
// A tick sweeps the partial memories of both channels together, one partial per
// cycle through a read, phase update, table lookup, multiply and accumulate
// pipeline, and the scaled sample of each lane is registered before the output
// register takes it. A write passes through the memory read and the three-stage
// increment calculation.
// With playing disabled a tick gives zeros.
// The block takes one request at a time; in_stall_o is high while one is at work.
// After reset both partial memories are cleared, one entry per cycle; no request
// is taken meanwhile, while the register port works.
// A finished frame waits in the output register while out_stall_i is high; the
// next request is still taken, and a following tick holds its frame until the
// output register is free.
module additive_wavetable_oscillator_bank (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [awo_pkg::ADDR_W-1:0]    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  awo_pkg::in_req_t              in_req_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output awo_pkg::out_rsp_t             out_rsp_o
);
  import awo_pkg::*;

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_WR_RD  = 3'd2;
  localparam logic [2:0] S_WR_DIV = 3'd3;
  localparam logic [2:0] S_TICK   = 3'd4;
  localparam logic [2:0] S_DRAIN  = 3'd5;
  localparam logic [2:0] S_PUSH   = 3'd6;

  logic [2:0]        state_q, state_d;
  logic [IDX_W-1:0]  cnt_q, cnt_d;
  in_req_t           req_q;
  logic              silent_q, silent_d;
  logic              play_q;
  logic              out_valid_q;
  out_rsp_t          out_rsp_q;

  logic              in_accept;
  logic              cfg_write;
  logic              reg_sel;
  logic              cnt_last;
  logic              wr_left;
  logic              div_start;
  logic              div_done;
  logic [INC_W-1:0]  div_inc;
  lane_ctl_t         left_ctl, right_ctl;
  logic              left_done, right_done;
  logic signed [SMP_W-1:0] left_smp, right_smp;
  logic              out_load;

  // register port
  assign pready    = 1'b1;
  assign reg_sel   = (paddr[ADDR_W-1:2] == REG_PLAY_ENABLE);
  assign cfg_write = psel && penable && pwrite && pready && reg_sel;
  assign prdata    = reg_sel ? {31'b0, play_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      play_q <= 1'b0;
    end else if (cfg_write) begin
      play_q <= pwdata[0];
    end
  end

  // request handshake
  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign cnt_last   = (cnt_q == IDX_W'(PARTIALS - 1));
  assign wr_left    = (req_q.operation == OP_WR_LEFT);
  assign out_load   = (state_q == S_PUSH) && (!out_valid_q || !out_stall_i);

  // sequencer
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    silent_d  = silent_q;
    div_start = 1'b0;
    left_ctl  = '0;
    right_ctl = '0;
    left_ctl.addr  = IDX_W'(req_q.partial_index);
    right_ctl.addr = IDX_W'(req_q.partial_index);
    case (state_q)
      S_CLEAR: begin
        left_ctl.clr_wr  = 1'b1;
        right_ctl.clr_wr = 1'b1;
        left_ctl.addr    = cnt_q;
        right_ctl.addr   = cnt_q;
        cnt_d            = cnt_q + 1'b1;
        if (cnt_last) begin
          cnt_d   = '0;
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_accept) begin
          case (in_req_i.operation)
            OP_TICK: begin
              cnt_d = '0;
              if (play_q) begin
                silent_d = 1'b0;
                state_d  = S_TICK;
              end else begin
                silent_d = 1'b1;
                state_d  = S_PUSH;
              end
            end
            OP_WR_LEFT, OP_WR_RIGHT: begin
              if (32'(in_req_i.partial_index) < PARTIALS) begin
                state_d = S_WR_RD;
              end
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_WR_RD: begin
        div_start = 1'b1;
        if (wr_left) begin
          left_ctl.rd = 1'b1;
        end else begin
          right_ctl.rd = 1'b1;
        end
        state_d = S_WR_DIV;
      end
      S_WR_DIV: begin
        if (div_done) begin
          if (wr_left) begin
            left_ctl.cfg_wr = 1'b1;
          end else begin
            right_ctl.cfg_wr = 1'b1;
          end
          state_d = S_IDLE;
        end
      end
      S_TICK: begin
        left_ctl.rd       = 1'b1;
        left_ctl.tick     = 1'b1;
        left_ctl.last     = cnt_last;
        left_ctl.acc_clr  = (cnt_q == '0);
        left_ctl.addr     = cnt_q;
        right_ctl.rd      = 1'b1;
        right_ctl.tick    = 1'b1;
        right_ctl.last    = cnt_last;
        right_ctl.acc_clr = (cnt_q == '0);
        right_ctl.addr    = cnt_q;
        cnt_d             = cnt_q + 1'b1;
        if (cnt_last) begin
          cnt_d   = '0;
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (left_done && right_done) begin
          state_d = S_PUSH;
        end
      end
      S_PUSH: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      cnt_q    <= '0;
      silent_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      silent_q <= silent_d;
    end
  end

  // captured request
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      req_q <= in_req_i;
    end
  end

  // increment calculation, shared by both channels
  awo_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .hz_i    (req_q.frequency_hz),
    .done_o  (div_done),
    .inc_o   (div_inc)
  );

  // channel lanes
  awo_lane u_left (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (left_ctl),
    .amp_i    (req_q.amplitude),
    .inc_i    (div_inc),
    .done_o   (left_done),
    .sample_o (left_smp)
  );

  awo_lane u_right (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (right_ctl),
    .amp_i    (req_q.amplitude),
    .inc_i    (div_inc),
    .done_o   (right_done),
    .sample_o (right_smp)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_rsp_q.left_sample  <= silent_q ? '0 : left_smp;
      out_rsp_q.right_sample <= silent_q ? '0 : right_smp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

// File: sim/tb_additive_wavetable_oscillator_bank.sv
// self-checking testbench for the additive wavetable oscillator bank
module tb_additive_wavetable_oscillator_bank;
  import awo_pkg::*;

  localparam int CLK_PERIOD   = 12;
  localparam int LIMIT_CYCLES = 2500000;
  localparam int SETTLE       = 300;

  localparam logic [OP_W-1:0]   OP_SPARE    = 2'd3;
  localparam logic [ADDR_W-1:0] PLAY_ADDR   = {REG_PLAY_ENABLE, 2'b00};
  localparam logic [ADDR_W-1:0] UNUSED_ADDR = 3'd4;

  // quarter-wave sine in millionths
  localparam int unsigned QWAVE_MICRO [129] = '{
    0, 12268, 24536, 36804, 49042, 61310, 73547, 85785, 97992, 110200,
    122410, 134550, 146700, 158840, 170930, 183010, 195070, 207090, 219090, 231050,
    242950, 254850, 266690, 278500, 290250, 301970, 313660, 325290, 336850, 348390,
    359860, 371280, 382660, 393950, 405210, 416410, 427520, 438600, 449580, 460510,
    471370, 482150, 492860, 503510, 514070, 524570, 534970, 545290, 555540, 565700,
    575780, 585750, 595670, 605470, 615200, 624820, 634370, 643800, 653140, 662380,
    671510, 680570, 689510, 698330, 707060, 715700, 724210, 732600, 740910, 749080,
    757170, 765140, 772980, 780700, 788300, 795810, 803160, 810420, 817540, 824550,
    831420, 838200, 844820, 851320, 857700, 863920, 870060, 876040, 881870, 887600,
    893190, 898620, 903960, 909120, 914150, 919070, 923830, 928470, 932950, 937290,
    941500, 945560, 949490, 953250, 956910, 960390, 963750, 966920, 970000, 972900,
    975650, 978270, 980740, 983060, 985230, 987240, 989140, 990840, 992430, 993870,
    995150, 996280, 997250, 998080, 998750, 999270, 999660, 999880, 999970
  };

  // oscillator bank model and queue of frames still to come
  class frame_board;
    bit          play;
    logic [24:0] phase [2][PARTIALS];
    logic [15:0] amp   [2][PARTIALS];
    logic [13:0] freq  [2][PARTIALS];
    out_rsp_t    frames_due [$];
    int unsigned errors;

    function new();
      play   = 1'b0;
      errors = 0;
      for (int c = 0; c < 2; c++) begin
        for (int n = 0; n < PARTIALS; n++) begin
          phase[c][n] = '0;
          amp[c][n]   = '0;
          freq[c][n]  = '0;
        end
      end
    endfunction

    function void set_play(bit v);
      play = v;
    endfunction

    function int pending();
      return frames_due.size();
    endfunction

    // mirrored table entry in q1.15
    function longint sine_q15(int unsigned i);
      int unsigned j;
      int unsigned k;
      bit          neg;
      longint      mag;
      j = i % 512;
      if (j <= 128) begin
        k = j; neg = 1'b0;
      end else if (j <= 256) begin
        k = 256 - j; neg = 1'b0;
      end else if (j <= 384) begin
        k = j - 256; neg = 1'b1;
      end else begin
        k = 512 - j; neg = 1'b1;
      end
      mag = (longint'(QWAVE_MICRO[k]) * 32768 + 500000) / 1000000;
      return neg ? -mag : mag;
    endfunction

    // step every sounding partial of one channel, sum in q.31
    function longint render_channel(int ch);
      longint acc;
      longint inc;
      longint p;
      acc = 0;
      for (int n = 0; n < PARTIALS; n++) begin
        if (amp[ch][n] == 0) continue;
        inc = ((longint'(freq[ch][n]) << 25) + 22050) / 44100;
        p   = longint'(phase[ch][n]) + inc;
        // wrap a full turn, clamp the last table step to zero
        if (p >= (longint'(512) << 16)) p -= (longint'(512) << 16);
        else if (p >= (longint'(511) << 16)) p = 0;
        phase[ch][n] = 25'(p);
        acc += sine_q15(1 + int'(p >> 16)) * longint'(amp[ch][n]);
      end
      return acc;
    endfunction

    // divide by ten, clamp, scale by 0.85, round half away from zero
    function logic [15:0] scale_to_q15(longint s);
      longint lim;
      longint mag;
      longint q;
      lim = longint'(10) << 31;
      if (s > lim) s = lim;
      if (s < -lim) s = -lim;
      mag = (s < 0) ? -s : s;
      q   = (mag * 17 + 6553600) / 13107200;
      if (s < 0) q = -q;
      return 16'(q);
    endfunction

    function void note_request(in_req_t r);
      out_rsp_t f;
      case (r.operation)
        OP_WR_LEFT, OP_WR_RIGHT: begin
          if (int'(r.partial_index) < PARTIALS) begin
            amp[r.operation == OP_WR_RIGHT][r.partial_index]  = r.amplitude;
            freq[r.operation == OP_WR_RIGHT][r.partial_index] = r.frequency_hz;
          end
        end
        OP_TICK: begin
          if (play) begin
            f.left_sample  = scale_to_q15(render_channel(0));
            f.right_sample = scale_to_q15(render_channel(1));
          end else begin
            f = '0;
          end
          frames_due.push_back(f);
        end
        default: ;
      endcase
    endfunction

    function void check_frame(out_rsp_t got);
      out_rsp_t want;
      if (frames_due.size() == 0) begin
        $display("%0t unexpected frame left %0d right %0d", $time,
                 got.left_sample, got.right_sample);
        errors++;
        return;
      end
      want = frames_due.pop_front();
      if (got.left_sample !== want.left_sample) begin
        $display("%0t left_sample expected %0d got %0d", $time,
                 want.left_sample, got.left_sample);
        errors++;
      end
      if (got.right_sample !== want.right_sample) begin
        $display("%0t right_sample expected %0d got %0d", $time,
                 want.right_sample, got.right_sample);
        errors++;
      end
    endfunction
  endclass

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              psel        = 1'b0;
  logic              penable     = 1'b0;
  logic              pwrite      = 1'b0;
  logic [ADDR_W-1:0] paddr       = '0;
  logic [31:0]       pwdata      = '0;
  logic [31:0]       prdata;
  logic              pready;
  logic              in_valid_i  = 1'b0;
  logic              in_stall_o;
  in_req_t           in_req_i    = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  out_rsp_t          out_rsp_o;

  frame_board  board;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  int unsigned stall_run     = 0;

  additive_wavetable_oscillator_bank dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // receiver stalls in runs, now and then a long one to back up frames
  always @(posedge clk_i) begin
    if (stall_run == 0) begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
      stall_run   <= $urandom_range(1, ($urandom_range(9) == 0) ? 400 : 6);
    end else begin
      stall_run <= stall_run - 1;
    end
  end

  // check frames leaving the block, predict on requests taken
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) board.check_frame(out_rsp_o);
    if (rst_ni && in_valid_i && !in_stall_o) board.note_request(in_req_i);
  end

  function automatic in_req_t make_request(logic [OP_W-1:0] op, int unsigned idx,
                                           int unsigned a, int unsigned hz);
    in_req_t r;
    r.operation     = op;
    r.partial_index = PIDX_W'(idx);
    r.amplitude     = AMP_W'(a);
    r.frequency_hz  = HZ_W'(hz);
    return r;
  endfunction

  function automatic in_req_t random_request();
    in_req_t     r;
    int unsigned pick;
    pick = $urandom_range(99);
    r.operation = (pick < 45) ? OP_TICK : (pick < 70) ? OP_WR_LEFT :
                  (pick < 95) ? OP_WR_RIGHT : OP_SPARE;
    r.partial_index = PIDX_W'($urandom_range(255));
    pick = $urandom_range(9);
    r.amplitude = (pick == 0) ? '0 : (pick == 1) ? '1 : AMP_W'($urandom);
    pick = $urandom_range(9);
    r.frequency_hz = (pick == 0) ? '0 : (pick == 1) ? '1 : HZ_W'($urandom);
    return r;
  endfunction

  // offer one request, with an optional gap before it, until taken
  task automatic send_request(in_req_t r);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, ($urandom_range(3) == 0) ? 300 : 4)) @(posedge clk_i);
    end
    in_req_i   <= r;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // stop offering and wait for every frame, then let a write finish
  task automatic drain();
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic reg_write(logic [ADDR_W-1:0] a, logic [31:0] d);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= a;
    pwdata  <= d;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (a == PLAY_ADDR) board.set_play(d[0]);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic reg_read_check();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= PLAY_ADDR;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== {31'b0, board.play}) begin
      $display("%0t play_enable read expected %0d got %0d", $time, board.play, prdata);
      board.errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic random_phase(int unsigned count, int unsigned idle, int unsigned stall,
                              bit mid_pause);
    send_idle_pct = idle;
    stall_pct     = stall;
    for (int unsigned k = 0; k < count; k++) begin
      if (mid_pause && k == count / 2) drain();
      send_request(random_request());
    end
    drain();
  endtask

  initial begin
    board = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // playing disabled after reset: silent frames, phases hold
    reg_read_check();
    send_request(make_request(OP_WR_LEFT, 0, 16'hFFFF, 14'h3FFF));
    send_request(make_request(OP_TICK, 0, 0, 0));
    send_request(make_request(OP_SPARE, 255, 16'hFFFF, 14'h3FFF));
    send_request(make_request(OP_TICK, 255, 16'hFFFF, 14'h3FFF));
    drain();

    // unknown register is ignored, then enable playing
    reg_write(UNUSED_ADDR, 32'hFFFF_FFFF);
    reg_read_check();
    reg_write(PLAY_ADDR, 32'hFFFF_FFFF);
    reg_read_check();

    // twelve full-scale partials at a quarter of the rate drive both clamps
    for (int n = 0; n < 12; n++) send_request(make_request(OP_WR_LEFT, n, 16'hFFFF, 11025));
    // phase lands just under a full turn on the third tick and clamps to zero
    send_request(make_request(OP_WR_RIGHT, 255, 16'hFFFF, 14677));
    send_request(make_request(OP_WR_RIGHT, 0, 0, 16383));
    send_request(make_request(OP_WR_RIGHT, 1, 1, 0));
    repeat (4) send_request(make_request(OP_TICK, 0, 0, 0));
    send_request(make_request(OP_SPARE, 0, 0, 0));
    drain();

    // random traffic under the different idle patterns
    random_phase(110, 0, 0, 1'b0);
    reg_write(PLAY_ADDR, 32'hFFFF_FFFE);
    reg_read_check();
    random_phase(50, 62, 0, 1'b0);
    reg_write(PLAY_ADDR, 32'h0000_0001);
    random_phase(110, 0, 62, 1'b1);
    reg_write(PLAY_ADDR, 32'h0000_0000);
    reg_write(PLAY_ADDR, 32'h0000_0001);
    reg_read_check();
    random_phase(110, 35, 35, 1'b0);

    if (board.errors == 0 && board.pending() == 0) begin
      $display("tb_additive_wavetable_oscillator_bank: PASS");
    end else begin
      $display("tb_additive_wavetable_oscillator_bank: FAIL");
    end
    $finish;
  end

  // hang guard
  initial begin
    #(CLK_PERIOD * LIMIT_CYCLES);
    $display("tb_additive_wavetable_oscillator_bank: FAIL");
    $finish;
  end

endmodule
